/* rtl/lsog_pkg.sv */
// Package for the lidar scan to occupancy grid block.
// Holds grid geometry, item structs, datapath command codes and the
// controller/datapath command and status structs. No dependencies.
package lsog_pkg;

  localparam int GRID_WIDTH  = 80;
  localparam int GRID_HEIGHT = 80;
  localparam int MAX_BEAMS   = 1024;

  localparam int BEAM_W  = $clog2(MAX_BEAMS);
  localparam int COL_W   = 7;
  localparam int ROW_W   = 7;
  localparam int COST_W  = 6;
  localparam int RANGE_W = 16;
  localparam int REG_W   = 16;
  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  localparam int CORDIC_STEPS = 14;
  localparam int DIV_BITS     = 8;
  localparam int CNT_W        = 7;

  localparam logic [1:0] OP_RANGE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [COST_W-1:0] COST_FREE = 6'd50;
  localparam logic [COST_W-1:0] COST_OCC  = 6'd0;

  localparam logic [4:0] DP_NOP   = 5'd0;
  localparam logic [4:0] DP_ACC   = 5'd1;
  localparam logic [4:0] DP_CLR   = 5'd2;
  localparam logic [4:0] DP_LOADB = 5'd3;
  localparam logic [4:0] DP_CSTEP = 5'd4;
  localparam logic [4:0] DP_MULX  = 5'd5;
  localparam logic [4:0] DP_MULY  = 5'd6;
  localparam logic [4:0] DP_GY    = 5'd7;
  localparam logic [4:0] DP_LOADY = 5'd8;
  localparam logic [4:0] DP_SMX   = 5'd9;
  localparam logic [4:0] DP_DLX   = 5'd10;
  localparam logic [4:0] DP_DSTEP = 5'd11;
  localparam logic [4:0] DP_DFX   = 5'd12;
  localparam logic [4:0] DP_SMY   = 5'd13;
  localparam logic [4:0] DP_DLY   = 5'd14;
  localparam logic [4:0] DP_DFY   = 5'd15;
  localparam logic [4:0] DP_MRD   = 5'd16;
  localparam logic [4:0] DP_MWR   = 5'd17;
  localparam logic [4:0] DP_RRD   = 5'd18;
  localparam logic [4:0] DP_OUT   = 5'd19;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [RANGE_W-1:0] range_mm;
    logic [COL_W-1:0]   read_col;
    logic [ROW_W-1:0]   read_row;
  } in_item_t;

  typedef struct packed {
    logic [BEAM_W-1:0] beam_number;
    logic              hit;
    logic [COL_W-1:0]  cell_col;
    logic [ROW_W-1:0]  cell_row;
    logic [COST_W-1:0] cell_cost;
  } out_item_t;

  typedef struct packed {
    logic [4:0]       op;
    logic [CNT_W-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic range_ok;
    logic hit;
  } dp_sts_t;

endpackage

/* rtl/lidar_scan_to_occupancy_grid.sv */
// Top level of the lidar scan to occupancy grid block.
// Joins lsog_ctrl and lsog_dp; depends on lsog_pkg.
//
// Input channel in_valid_i/in_stall_o carries one item: a range sample,
// a start scan, or a cell read. Output channel out_valid_o/out_stall_i
// returns one result item per input item, from an output register, so a
// new item is taken while the previous result still waits.
// Configuration: cfg_we_i, cfg_idx_i, cfg_wdata_i write one register per
// cycle; write only while the block is idle.
// Per item: a range sample that marks a cell runs two passes of a 14-step
// iterative CORDIC with gain multiplies, two reciprocal cell divides and a
// row read-modify-write of the grid; in range but off the grid it skips the
// write; out of range it skips the CORDIC and divides. A start scan runs
// the 80-row clearing sweep. The next item can be taken in the cycle after
// the result loads.
// After reset the block sweeps all 80 rows of the grid memory clear and
// holds in_stall_o high meanwhile. A stalled result holds its payload;
// the block finishes the next item and then waits with in_stall_o high.
module lidar_scan_to_occupancy_grid import lsog_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  lsog_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_data_i.opcode),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lsog_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/lsog_dp.sv */
// Datapath: config registers, beam counter, iterative CORDIC, shared
// product register, reciprocal cell divide and the row-wide grid memory.
// Depends on lsog_pkg; driven by lsog_ctrl commands.
module lsog_dp import lsog_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_wdata_i,
  input  in_item_t             in_data_i,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o,
  output out_item_t            out_data_o
);

  localparam int COORD_W = 28;
  localparam int Z_W     = 18;
  localparam int PROD_W  = 46;
  localparam int N_W     = 48;
  localparam int REM_W   = 35;
  localparam longint SCALE_DEN = 64'd131072000;
  localparam longint HALF_DEN  = 64'd65536000;
  localparam longint CELLS_X   = longint'(GRID_WIDTH) * HALF_DEN;
  localparam longint CELLS_Y   = longint'(GRID_HEIGHT) * HALF_DEN;
  localparam longint DIV_LIM   = SCALE_DEN * (64'd1 << DIV_BITS);
  localparam logic [16:0] GAIN_Q16 = 17'd39797;
  // SCALE_DEN = 1000 << 17; t / 1000 = (t * 67109) >> 26, exact for t < 2^18
  localparam int DEN_SH   = 17;
  localparam int T_W      = REM_W - DEN_SH;
  localparam int RECIP_SH = 26;
  localparam logic [16:0] RECIP_Q26 = 17'd67109;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [Z_W-1:0]     z;
  } rot_t;

  function automatic logic signed [Z_W-1:0] atan_turns(input logic [3:0] i);
    logic signed [Z_W-1:0] a;
    unique case (i)
      4'd0:    a = 18'sd8192;
      4'd1:    a = 18'sd4836;
      4'd2:    a = 18'sd2555;
      4'd3:    a = 18'sd1297;
      4'd4:    a = 18'sd651;
      4'd5:    a = 18'sd326;
      4'd6:    a = 18'sd163;
      4'd7:    a = 18'sd81;
      4'd8:    a = 18'sd41;
      4'd9:    a = 18'sd20;
      4'd10:   a = 18'sd10;
      4'd11:   a = 18'sd5;
      4'd12:   a = 18'sd3;
      4'd13:   a = 18'sd1;
      default: a = 18'sd0;
    endcase
    return a;
  endfunction

  function automatic rot_t quarter(input logic signed [COORD_W-1:0] x,
                                   input logic signed [COORD_W-1:0] y,
                                   input logic [15:0] u);
    rot_t r;
    logic [15:0] up;
    logic [1:0]  q;
    logic [15:0] res;
    up  = u + 16'd8192;
    q   = up[15:14];
    res = u - {q, 14'b0};
    r.z = Z_W'($signed(res));
    unique case (q)
      2'd1: begin r.x = -y; r.y = x; end
      2'd2: begin r.x = -x; r.y = -y; end
      2'd3: begin r.x = y; r.y = -x; end
      default: begin r.x = x; r.y = y; end
    endcase
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] gain_fix(
      input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = (p + PROD_W'(32768)) >>> 16;
    return s[COORD_W-1:0];
  endfunction

  logic [REG_W-1:0] cfg_q [NUM_REGS];
  in_item_t item_q;
  logic [BEAM_W-1:0] beam_cnt_q, beam_q;
  logic range_ok_q, hit_q, axis_ok_q;
  logic signed [COORD_W-1:0] x_q, y_q;
  logic signed [Z_W-1:0] z_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [REM_W-1:0] rem_q;
  logic [DIV_BITS-1:0] quo_q;
  logic ovf_q, neg_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [GRID_WIDTH-1:0] mem [GRID_HEIGHT];
  logic [GRID_WIDTH-1:0] rd_q;
  out_item_t out_q;

  logic [BEAM_W+REG_W-1:0] ang_p;
  logic [15:0] beam_ang;
  rot_t rot_b, rot_y;
  logic signed [COORD_W-1:0] dx, dy, xo, yo;
  logic signed [Z_W-1:0] at;
  logic signed [N_W-1:0] n_x, n_y, n_sel, mag;
  logic [N_W-1:0] m;
  logic [T_W-1:0] div_t;
  logic [REM_W-1:0] div_p;
  logic q_ok;
  logic rd_ok;
  logic [COL_W-1:0] rc_sel;
  logic [ROW_W-1:0] rr_sel;
  out_item_t out_d;

  always_comb begin
    ang_p    = beam_q * cfg_q[1];
    beam_ang = cfg_q[0] + ang_p[15:0];
    rot_b    = quarter(COORD_W'($signed({1'b0, item_q.range_mm, 8'b0})), '0, beam_ang);
    xo       = x_q + {{(COORD_W-24){cfg_q[4][15]}}, cfg_q[4], 8'b0};
    yo       = y_q + {{(COORD_W-24){cfg_q[5][15]}}, cfg_q[5], 8'b0};
    rot_y    = quarter(xo, yo, cfg_q[6]);
    dx       = y_q >>> cmd_i.step[3:0];
    dy       = x_q >>> cmd_i.step[3:0];
    at       = atan_turns(cmd_i.step[3:0]);
    n_x      = (N_W'(prod_q) <<< 1) + N_W'(CELLS_X);
    n_y      = (N_W'(prod_q) <<< 1) + N_W'(CELLS_Y);
    n_sel    = (cmd_i.op == DP_DLY) ? n_y : n_x;
    mag      = n_sel[N_W-1] ? -n_sel : n_sel;
    m        = $unsigned(mag) + N_W'(HALF_DEN);
    div_t    = rem_q[REM_W-1:DEN_SH];
    div_p    = {{(REM_W-T_W){1'b0}}, div_t} * {{(REM_W-17){1'b0}}, RECIP_Q26};
    q_ok     = !ovf_q && (neg_q ? (quo_q == '0) : 1'b1);
    rd_ok    = (item_q.read_col < COL_W'(GRID_WIDTH)) &&
               (item_q.read_row < ROW_W'(GRID_HEIGHT));
    rc_sel   = rd_ok ? item_q.read_col : '0;
    rr_sel   = (in_data_i.read_row < ROW_W'(GRID_HEIGHT)) ? in_data_i.read_row : '0;
    out_d    = '0;
    if (item_q.opcode == OP_RANGE) begin
      out_d.beam_number = beam_q;
      out_d.hit         = hit_q;
      out_d.cell_col    = hit_q ? col_q : '0;
      out_d.cell_row    = hit_q ? row_q : '0;
    end else if (item_q.opcode == OP_READ) begin
      out_d.cell_col  = item_q.read_col;
      out_d.cell_row  = item_q.read_row;
      out_d.cell_cost = (rd_ok && rd_q[rc_sel]) ? COST_OCC : COST_FREE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[0]   <= 16'h8000;
      cfg_q[1]   <= 16'd64;
      cfg_q[2]   <= 16'd100;
      cfg_q[3]   <= 16'd30000;
      cfg_q[4]   <= 16'd0;
      cfg_q[5]   <= 16'd0;
      cfg_q[6]   <= 16'd0;
      cfg_q[7]   <= 16'd5120;
      beam_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q[cfg_idx_i] <= cfg_wdata_i;
      end
      if (cmd_i.op == DP_ACC) begin
        if (in_data_i.opcode == OP_RANGE) begin
          beam_cnt_q <= beam_cnt_q + 1'b1;
        end else if (in_data_i.opcode == OP_START) begin
          beam_cnt_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_ACC: begin
        item_q     <= in_data_i;
        beam_q     <= beam_cnt_q;
        hit_q      <= 1'b0;
        range_ok_q <= (in_data_i.range_mm > cfg_q[2]) && (in_data_i.range_mm < cfg_q[3]);
        rd_q       <= mem[rr_sel];
      end
      DP_LOADB: begin
        x_q <= rot_b.x;
        y_q <= rot_b.y;
        z_q <= rot_b.z;
      end
      DP_LOADY: begin
        x_q <= rot_y.x;
        y_q <= rot_y.y;
        z_q <= rot_y.z;
      end
      DP_CSTEP: begin
        if (!z_q[Z_W-1]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + at;
        end
      end
      DP_MULX: prod_q <= x_q * $signed(GAIN_Q16);
      DP_MULY: begin
        x_q    <= gain_fix(prod_q);
        prod_q <= y_q * $signed(GAIN_Q16);
      end
      DP_GY:  y_q    <= gain_fix(prod_q);
      DP_SMX: prod_q <= x_q * $signed({1'b0, cfg_q[7]});
      DP_SMY: prod_q <= y_q * $signed({1'b0, cfg_q[7]});
      DP_DLX, DP_DLY: begin
        neg_q <= n_sel[N_W-1];
        ovf_q <= m >= N_W'(DIV_LIM);
        rem_q <= m[REM_W-1:0];
        quo_q <= '0;
      end
      DP_DSTEP: quo_q <= div_p[RECIP_SH +: DIV_BITS];
      DP_DFX: begin
        axis_ok_q <= q_ok && (quo_q < DIV_BITS'(GRID_WIDTH));
        col_q     <= quo_q[COL_W-1:0];
      end
      DP_DFY: begin
        hit_q <= range_ok_q && axis_ok_q && q_ok && (quo_q < DIV_BITS'(GRID_HEIGHT));
        row_q <= quo_q[ROW_W-1:0];
      end
      DP_MRD: rd_q <= mem[row_q];
      DP_OUT: out_q <= out_d;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_CLR) begin
      mem[cmd_i.step] <= '0;
    end else if (cmd_i.op == DP_MWR) begin
      mem[row_q] <= rd_q | (GRID_WIDTH'(1) << col_q);
    end
  end

  assign sts_o.range_ok = range_ok_q;
  assign sts_o.hit      = hit_q;
  assign out_data_o     = out_q;

endmodule

/* rtl/lsog_ctrl.sv */
// Controller state machine: handshakes, clearing sweep and the
// command sequence for the datapath. Depends on lsog_pkg.
module lsog_ctrl import lsog_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_opcode_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_sts_t    sts_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLR   = 5'd1;
  localparam logic [4:0] S_LOADB = 5'd2;
  localparam logic [4:0] S_CORD  = 5'd3;
  localparam logic [4:0] S_MULX  = 5'd4;
  localparam logic [4:0] S_MULY  = 5'd5;
  localparam logic [4:0] S_GY    = 5'd6;
  localparam logic [4:0] S_LOADY = 5'd7;
  localparam logic [4:0] S_SMX   = 5'd8;
  localparam logic [4:0] S_DLX   = 5'd9;
  localparam logic [4:0] S_DIVX  = 5'd10;
  localparam logic [4:0] S_DFX   = 5'd11;
  localparam logic [4:0] S_SMY   = 5'd12;
  localparam logic [4:0] S_DLY   = 5'd13;
  localparam logic [4:0] S_DIVY  = 5'd14;
  localparam logic [4:0] S_DFY   = 5'd15;
  localparam logic [4:0] S_MRD   = 5'd16;
  localparam logic [4:0] S_MWR   = 5'd17;
  localparam logic [4:0] S_OUT   = 5'd18;

  logic [4:0] state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic pass_q, pass_d;
  logic clr_item_q, clr_item_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pass_d      = pass_q;
    clr_item_d  = clr_item_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = DP_NOP;
    cmd_o.step  = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_ACC;
          cnt_d    = '0;
          priority case (in_opcode_i)
            OP_RANGE: state_d = S_LOADB;
            OP_START: begin state_d = S_CLR; clr_item_d = 1'b1; end
            default:  state_d = S_OUT;
          endcase
        end
      end
      S_CLR: begin
        cmd_o.op = DP_CLR;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(GRID_HEIGHT - 1)) begin
          state_d = clr_item_q ? S_OUT : S_IDLE;
        end
      end
      S_LOADB: begin
        cmd_o.op = DP_LOADB;
        pass_d   = 1'b0;
        cnt_d    = '0;
        state_d  = sts_i.range_ok ? S_CORD : S_OUT;
      end
      S_CORD: begin
        cmd_o.op = DP_CSTEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
          state_d = S_MULX;
        end
      end
      S_MULX: begin cmd_o.op = DP_MULX; state_d = S_MULY; end
      S_MULY: begin cmd_o.op = DP_MULY; state_d = S_GY; end
      S_GY: begin
        cmd_o.op = DP_GY;
        state_d  = pass_q ? S_SMX : S_LOADY;
      end
      S_LOADY: begin
        cmd_o.op = DP_LOADY;
        pass_d   = 1'b1;
        cnt_d    = '0;
        state_d  = S_CORD;
      end
      S_SMX: begin cmd_o.op = DP_SMX; state_d = S_DLX; end
      S_DLX: begin cmd_o.op = DP_DLX; state_d = S_DIVX; end
      S_DIVX: begin cmd_o.op = DP_DSTEP; state_d = S_DFX; end
      S_DFX: begin cmd_o.op = DP_DFX; state_d = S_SMY; end
      S_SMY: begin cmd_o.op = DP_SMY; state_d = S_DLY; end
      S_DLY: begin cmd_o.op = DP_DLY; state_d = S_DIVY; end
      S_DIVY: begin cmd_o.op = DP_DSTEP; state_d = S_DFY; end
      S_DFY: begin cmd_o.op = DP_DFY; state_d = S_MRD; end
      S_MRD: begin
        if (sts_i.hit) begin
          cmd_o.op = DP_MRD;
          state_d  = S_MWR;
        end else begin
          state_d = S_OUT;
        end
      end
      S_MWR: begin cmd_o.op = DP_MWR; state_d = S_OUT; end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = DP_OUT;
          out_valid_d = 1'b1;
          clr_item_d  = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cnt_q       <= '0;
      pass_q      <= 1'b0;
      clr_item_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pass_q      <= pass_d;
      clr_item_q  <= clr_item_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_cord_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CORD) |-> (cnt_q < CNT_W'(CORDIC_STEPS)))
    else $error("cordic step count out of range");

  a_clr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> (cnt_q < CNT_W'(GRID_HEIGHT)))
    else $error("clear sweep row out of range");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result shown outside output state");

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q != S_IDLE))
    else $error("accepted item left no work");

endmodule

/* tb/sv/tb_lidar_scan_to_occupancy_grid.sv */
// Testbench for lidar_scan_to_occupancy_grid: directed and random items checked
// against a built-in occupancy grid predictor (CORDIC, gain, cell rounding).
// Depends on lsog_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb_lidar_scan_to_occupancy_grid;
  import lsog_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam longint CELL_DEN = 131072000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [REG_IDX_W-1:0] cfg_idx_i;
  logic [REG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_item_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_item_t            out_data_o;

  typedef enum int {
    REG_START_ANGLE, REG_ANGLE_STEP, REG_MIN_RANGE, REG_MAX_RANGE,
    REG_OFFSET_X, REG_OFFSET_Y, REG_YAW, REG_CELLS_PER_M
  } reg_e;

  logic [15:0] shadow_regs [NUM_REGS];
  bit          grid_occ [GRID_WIDTH*GRID_HEIGHT];
  int unsigned beam_cnt;
  out_item_t   expected_results [$];

  int   mismatches;
  int   results_seen;
  int   hits_seen;
  int   items_sent;
  int   idle_cycles;
  bit   no_idle;

  const longint atan_lut [CORDIC_STEPS] = '{8192, 4836, 2555, 1297, 651, 326, 163,
                                           81, 41, 20, 10, 5, 3, 1};

  lidar_scan_to_occupancy_grid dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void beam_rotate(inout longint px, inout longint py,
                                      input logic [15:0] angle);
    logic [15:0] residue;
    logic [1:0]  quadrant;
    longint      x, y, z, t, dx, dy;
    quadrant = 2'((32'(angle) + 8192) >> 14);
    residue  = angle - {quadrant, 14'd0};
    z = longint'($signed(residue));
    x = px;
    y = py;
    case (quadrant)
      2'd1: begin t = x; x = -y; y = t; end
      2'd2: begin x = -x; y = -y; end
      2'd3: begin t = x; x = y; y = -t; end
      default: ;
    endcase
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_lut[i];
      end else begin
        x += dx; y -= dy; z += atan_lut[i];
      end
    end
    px = floor_shift(x * 39797 + 32768, 16);
    py = floor_shift(y * 39797 + 32768, 16);
  endfunction

  function automatic longint cell_index(longint p, longint cells);
    longint n;
    n = 2 * p * longint'(shadow_regs[REG_CELLS_PER_M]) + cells * 65536000;
    if (n >= 0) return (n + CELL_DEN / 2) / CELL_DEN;
    return -((-n + CELL_DEN / 2) / CELL_DEN);
  endfunction

  function automatic out_item_t predict_grid(in_item_t item);
    out_item_t   res;
    longint      x, y, cx, cy;
    logic [15:0] ang;
    res = '0;
    case (item.opcode)
      OP_START: begin
        foreach (grid_occ[i]) grid_occ[i] = 1'b0;
        beam_cnt = 0;
      end
      OP_READ: begin
        res.cell_col  = item.read_col;
        res.cell_row  = item.read_row;
        res.cell_cost = COST_FREE;
        if (item.read_col < GRID_WIDTH && item.read_row < GRID_HEIGHT &&
            grid_occ[item.read_row * GRID_WIDTH + item.read_col])
          res.cell_cost = COST_OCC;
      end
      OP_RANGE: begin
        res.beam_number = BEAM_W'(beam_cnt);
        if (item.range_mm > shadow_regs[REG_MIN_RANGE] &&
            item.range_mm < shadow_regs[REG_MAX_RANGE]) begin
          ang = shadow_regs[REG_START_ANGLE] + 16'(beam_cnt * shadow_regs[REG_ANGLE_STEP]);
          x = longint'(item.range_mm) * 256;
          y = 0;
          beam_rotate(x, y, ang);
          x += longint'($signed(shadow_regs[REG_OFFSET_X])) * 256;
          y += longint'($signed(shadow_regs[REG_OFFSET_Y])) * 256;
          beam_rotate(x, y, shadow_regs[REG_YAW]);
          cx = cell_index(x, GRID_WIDTH);
          cy = cell_index(y, GRID_HEIGHT);
          if (cx >= 0 && cy >= 0 && cx < GRID_WIDTH && cy < GRID_HEIGHT) begin
            grid_occ[cy * GRID_WIDTH + cx] = 1'b1;
            res.hit      = 1'b1;
            res.cell_col = COL_W'(cx);
            res.cell_row = ROW_W'(cy);
          end
        end
        beam_cnt = (beam_cnt + 1) % MAX_BEAMS;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic bit take_gap();
    return !no_idle && ($urandom_range(99) < 6);
  endfunction

  // result checker, random stall on the output side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data_o);
        end else begin
          out_item_t e;
          e = expected_results.pop_front();
          if (out_data_o.hit) hits_seen++;
          if (out_data_o.beam_number !== e.beam_number || out_data_o.hit !== e.hit ||
              out_data_o.cell_col !== e.cell_col || out_data_o.cell_row !== e.cell_row ||
              out_data_o.cell_cost !== e.cell_cost) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", e, out_data_o);
          end
        end
      end
      out_stall_i <= take_gap();
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog expired");
      $display("lidar_scan_to_occupancy_grid regression: fail");
      $finish;
    end
  end

  // valid stays high after an accept until the next item or a gap replaces it
  task automatic send_item(in_item_t item);
    cfg_we_i <= 1'b0;
    while (take_gap()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.insert(expected_results.size(), predict_grid(item));
    items_sent++;
  endtask

  task automatic write_reg(reg_e idx, logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_IDX_W'(idx);
    cfg_wdata_i <= value;
    @(posedge clk_i);
    shadow_regs[idx] = value;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic send_range(logic [15:0] r);
    send_item('{opcode: OP_RANGE, range_mm: r, read_col: 7'($urandom), read_row: 7'($urandom)});
  endtask

  task automatic send_read(logic [6:0] c, logic [6:0] r);
    send_item('{opcode: OP_READ, range_mm: 16'($urandom), read_col: c, read_row: r});
  endtask

  task automatic send_start();
    send_item('{opcode: OP_START, range_mm: 16'($urandom), read_col: 7'($urandom),
                read_row: 7'($urandom)});
  endtask

  task automatic test_directed();
    send_range(16'd0);
    send_range(16'd100);
    send_range(16'd101);
    send_range(16'd1000);
    send_range(16'd29999);
    send_range(16'd30000);
    send_range(16'hFFFF);
    send_read(7'd40, 7'd40);
    send_read(7'd0, 7'd0);
    send_read(7'd79, 7'd79);
    send_read(7'd80, 7'd10);
    send_read(7'd10, 7'd127);
    send_item('{opcode: 2'd3, range_mm: 16'hFFFF, read_col: 7'h7F, read_row: 7'h7F});
    send_start();
    send_read(7'd40, 7'd40);
    drain();
  endtask

  task automatic test_config_sweep();
    write_reg(REG_CELLS_PER_M, 16'd0);
    write_reg(REG_MIN_RANGE, 16'd0);
    write_reg(REG_MAX_RANGE, 16'hFFFF);
    send_range(16'd1);
    send_range(16'hFFFE);
    send_read(7'd40, 7'd40);
    drain();
    write_reg(REG_CELLS_PER_M, 16'hFFFF);
    write_reg(REG_START_ANGLE, 16'h7FFF);
    write_reg(REG_ANGLE_STEP, 16'h8000);
    write_reg(REG_OFFSET_X, 16'h8000);
    write_reg(REG_OFFSET_Y, 16'h7FFF);
    write_reg(REG_YAW, 16'h8000);
    send_range(16'd5);
    send_range(16'd40);
    drain();
    write_reg(REG_YAW, 16'h7FFF);
    write_reg(REG_OFFSET_X, 16'h7FFF);
    write_reg(REG_OFFSET_Y, 16'h8000);
    send_range(16'd10);
    drain();
  endtask

  task automatic random_phase(int n);
    int kind;
    write_reg(REG_START_ANGLE, 16'($urandom));
    write_reg(REG_ANGLE_STEP, 16'($urandom));
    write_reg(REG_MIN_RANGE, 16'($urandom_range(200)));
    write_reg(REG_MAX_RANGE, $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(9000)));
    write_reg(REG_OFFSET_X, 16'($signed($urandom_range(2000)) - 1000));
    write_reg(REG_OFFSET_Y, 16'($signed($urandom_range(2000)) - 1000));
    write_reg(REG_YAW, 16'($urandom));
    write_reg(REG_CELLS_PER_M, $urandom_range(4) == 0 ? 16'($urandom) :
                                16'($urandom_range(600, 5200)));
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) no_idle = 1'b1;
      if (i == n / 2 + n / 5) no_idle = 1'b0;
      kind = $urandom_range(99);
      if (kind < 2) send_start();
      else if (kind < 30) send_read(7'($urandom_range(85)), 7'($urandom_range(85)));
      else if (kind < 33) send_item('{opcode: 2'd3, range_mm: 16'($urandom),
                                      read_col: 7'($urandom), read_row: 7'($urandom)});
      else if (kind < 38) send_range(16'($urandom));
      else send_range(16'($urandom_range(9000)));
    end
    drain();
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    no_idle     = 1'b0;
    mismatches  = 0;
    results_seen = 0;
    hits_seen   = 0;
    items_sent  = 0;
    idle_cycles = 0;
    shadow_regs = '{16'h8000, 16'd64, 16'd100, 16'd30000, 16'd0, 16'd0, 16'd0, 16'd5120};
    foreach (grid_occ[i]) grid_occ[i] = 1'b0;
    beam_cnt = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_config_sweep();
    for (int p = 0; p < 6; p++) random_phase(270);
    $display("sent %0d items, checked %0d results, %0d beams hit the grid",
             items_sent, results_seen, hits_seen);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("lidar_scan_to_occupancy_grid regression: pass");
    else
      $display("lidar_scan_to_occupancy_grid regression: fail");
    $finish;
  end

endmodule
